@@ rtl/assert_macros.svh @@
// Assertion macros shared by the all-pole filter RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define AP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/apiw_pkg.sv @@
// Types, constants and helpers for the windowed all-pole filter.
// No dependencies; every other RTL module and interface imports this package.
`default_nettype none

package apiw_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int COEF_W   = 18;
	localparam int HIST_W   = 24;

	// Filter order range
	localparam int ORDER_DEFAULT = 6;
	localparam int ORDER_MAX     = 6;

	// Arithmetic widths
	localparam int BG_W    = 2 * COEF_W;              // b*g
	localparam int BGX_W   = BG_W + SAMPLE_W;         // b*g*x
	localparam int Y_SHIFT = 14;                      // Q3.14 coefficient scale
	localparam int W_SHIFT = 15;                      // Q1.15 weight scale
	localparam int F_W     = BGX_W - Y_SHIFT;         // rounded b*g*x
	localparam int PROD_W  = COEF_W + HIST_W;         // coef * history
	localparam int ACC_W   = PROD_W + 4;              // sum of ORDER_MAX taps and f
	localparam int WPROD_W = HIST_W + WEIGHT_W + 1;   // y * weight
	localparam int SAT_W   = 48;                      // saturation input width

	// Rounding offsets (half an output LSB)
	localparam int RND_Y = 1 << (Y_SHIFT - 1);
	localparam int RND_W = 1 << (W_SHIFT - 1);

	// Saturation limits
	localparam int HIST_MAX = (1 << (HIST_W - 1)) - 1;
	localparam int HIST_MIN = -(1 << (HIST_W - 1));

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_GAIN_B = 3'd0;
	localparam cfg_idx_t REG_GAIN_G = 3'd1;
	localparam cfg_idx_t REG_COEF_1 = 3'd2;

	// Reset values
	localparam int GAIN_RESET = 16384;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [WEIGHT_W-1:0]        weight_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [HIST_W-1:0]   hist_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [BG_W-1:0]     bg_t;

	// Per-cycle control for the history cells
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHAIN,
		S_SUM,
		S_WGT,
		S_OUT
	} apiw_state_t;

	// Clamp a wide signed value to the 24-bit history range
	function automatic hist_t sat_h(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(HIST_MAX);
		lo = SAT_W'(HIST_MIN);
		if (v > hi) begin
			return hist_t'(HIST_MAX);
		end else if (v < lo) begin
			return hist_t'(HIST_MIN);
		end
		return v[HIST_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/apiw_if.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on apiw_pkg for field types.
`default_nettype none

interface apiw_in_if import apiw_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	weight_t weight;
	logic    first;
	logic    last_in;

	modport source (output valid, sample, weight, first, last_in, input ready);
	modport sink (input valid, sample, weight, first, last_in, output ready);
endinterface

interface apiw_out_if import apiw_pkg::*; ();
	logic  valid;
	logic  ready;
	hist_t filtered;
	logic  last_out;

	modport source (output valid, filtered, last_out, input ready);
	modport sink (input valid, filtered, last_out, output ready);
endinterface

interface apiw_cfg_if import apiw_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	coef_t    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/apiw_cell.sv @@
// One tap of the feedback chain: holds one past output and adds its term.
// Depends on apiw_pkg.
`default_nettype none

module apiw_cell import apiw_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire coef_t     coef,
	input  wire hist_t     hist_in,
	input  wire acc_t      acc_in,
	output hist_t          hist_q,
	output acc_t           acc_q
);

	logic signed [PROD_W-1:0] prod;

	// Hold one history word; clear at block start, take the neighbor's on shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.clear) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= hist_in;
		end
	end

	// Add this tap's term to the running sum and hand it to the next cell
	assign prod = PROD_W'(coef) * PROD_W'(hist_q);

	always_ff @(posedge clk) begin
		acc_q <= acc_in + ACC_W'(prod);
	end

endmodule

`default_nettype wire

@@ rtl/apiw_cfg.sv @@
// Register file for gains and feedback coefficients, with the b*g product.
// Depends on apiw_pkg and apiw_if.
`default_nettype none

module apiw_cfg import apiw_pkg::*; #(
	parameter int ORDER = ORDER_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	apiw_cfg_if.sink   cfg,
	output bg_t        bg_q,
	output coef_t      coef_q [ORDER]
);

	coef_t gain_b_q;
	coef_t gain_g_q;
	logic  wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	// Write the gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_b_q <= coef_t'(GAIN_RESET);
			gain_g_q <= coef_t'(GAIN_RESET);
		end else if (wr) begin
			case (cfg.index)
				REG_GAIN_B: gain_b_q <= cfg.data;
				REG_GAIN_G: gain_g_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Write the coefficients in use; words for taps beyond the order drop
	for (genvar k = 0; k < ORDER; k++) begin : g_coef
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[k] <= '0;
			end else if (wr && cfg.index == CFG_IDX_W'(int'(REG_COEF_1) + k)) begin
				coef_q[k] <= cfg.data;
			end
		end
	end

	// Keep the combined input gain ready for the next sample
	always_ff @(posedge clk) begin
		bg_q <= BG_W'(gain_b_q) * BG_W'(gain_g_q);
	end

endmodule

`default_nettype wire

@@ rtl/all_pole_iir_with_window.sv @@
// Top level of the windowed all-pole filter: sequencer, cell chain, output.
// Depends on apiw_pkg, apiw_if, apiw_cfg, apiw_cell and assert_macros.svh.
//
//  port      dir   word contents
//  samples   in    sample (Q1.15), weight (Q1.15), first, last_in
//  results   out   filtered (Q8.15, saturated), last_out
//  cfg       in    index 0..7, data (18-bit Q3.14 gain or coefficient)
//
// For each word the sum ripples through the ORDER cells, then rounding,
// weighting and output follow. The next word is taken when the sequencer
// is back in idle; a held result stalls only the final load. Reset clears
// the state, history, gain, coefficient and output-valid registers at once.
`default_nettype none
`include "assert_macros.svh"

module all_pole_iir_with_window import apiw_pkg::*; #(
	parameter int ORDER = ORDER_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	apiw_in_if.sink    samples,
	apiw_out_if.source results,
	apiw_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(ORDER + 1);

	apiw_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic in_acc;
	logic out_load;
	logic chain_done;
	cell_ctl_t ctl;

	bg_t   bg_q;
	coef_t coef_q [ORDER];
	hist_t hist [ORDER];
	acc_t  acc [ORDER];

	sample_t x_q;
	weight_t w_q;
	logic    last_q;

	logic signed [BGX_W-1:0]   bgx;
	logic signed [F_W-1:0]     f_q;
	acc_t                      y_sum;
	logic signed [ACC_W-Y_SHIFT-1:0] y_rnd;
	hist_t                     y_q;
	logic signed [WPROD_W-1:0] prod_q;
	logic signed [WPROD_W-1:0] o_sum;
	logic signed [WPROD_W-W_SHIFT-1:0] o_rnd;

	logic  out_valid_q;
	hist_t out_filtered_q;
	logic  out_last_q;

	// Coefficient registers
	apiw_cfg #(.ORDER(ORDER)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.bg_q   (bg_q),
		.coef_q (coef_q)
	);

	// Chain of taps; cell 0 takes the new output on shift
	for (genvar k = 0; k < ORDER; k++) begin : g_cell
		if (k == 0) begin : g_head
			apiw_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.coef    (coef_q[k]),
				.hist_in (y_q),
				.acc_in  ('0),
				.hist_q  (hist[k]),
				.acc_q   (acc[k])
			);
		end else begin : g_body
			apiw_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.coef    (coef_q[k]),
				.hist_in (hist[k-1]),
				.acc_in  (acc[k-1]),
				.hist_q  (hist[k]),
				.acc_q   (acc[k])
			);
		end
	end

	assign in_acc     = samples.valid && samples.ready;
	assign chain_done = (cnt_q == CNT_W'(ORDER - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_acc) state_d = S_CHAIN;
			S_CHAIN: if (chain_done) state_d = S_SUM;
			S_SUM:   state_d = S_WGT;
			S_WGT:   state_d = S_OUT;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		samples.ready = 1'b0;
		ctl           = '0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				samples.ready = 1'b1;
				ctl.clear     = samples.valid && samples.first;
			end
			S_WGT: begin
				ctl.shift = 1'b1;
			end
			S_OUT: begin
				out_load = !out_valid_q || results.ready;
			end
			default: ;
		endcase
	end

	// Advance state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == S_CHAIN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= samples.sample;
			w_q    <= samples.weight;
			last_q <= samples.last_in;
		end
	end

	// Scaled input term, rounded to the accumulator scale
	assign bgx = BGX_W'(bg_q) * BGX_W'(x_q) + BGX_W'(RND_Y);

	always_ff @(posedge clk) begin
		if (state_q == S_CHAIN) begin
			f_q <= bgx[BGX_W-1:Y_SHIFT];
		end
	end

	// Combine feedback sum with the input term, round and saturate
	assign y_sum = acc[ORDER-1] - ACC_W'(f_q) + ACC_W'(RND_Y);
	assign y_rnd = y_sum[ACC_W-1:Y_SHIFT];

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			y_q <= sat_h(SAT_W'(y_rnd));
		end
	end

	// Apply the window weight
	always_ff @(posedge clk) begin
		if (state_q == S_WGT) begin
			prod_q <= WPROD_W'(y_q) * WPROD_W'(signed'({1'b0, w_q}));
		end
	end

	assign o_sum = prod_q + WPROD_W'(RND_W);
	assign o_rnd = o_sum[WPROD_W-1:W_SHIFT];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_filtered_q <= sat_h(SAT_W'(o_rnd));
			out_last_q     <= last_q;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.filtered = out_filtered_q;
	assign results.last_out = out_last_q;

	`AP_ASSERT_NEXT(a_accept_starts_chain, in_acc, state_q == S_CHAIN, "accepted word did not start the tap chain")
	`AP_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result appeared outside the output step")
	`AP_ASSERT_NEXT(a_head_takes_y, state_q == S_WGT, hist[0] == $past(y_q), "newest history word is not the new output")
	`AP_ASSERT_NEXT(a_first_clears, in_acc && samples.first, hist[ORDER-1] == '0, "block start left history uncleared")

endmodule

`default_nettype wire
